// File: rtl/core/tta_pkg.sv
package tta_pkg;

  // Field widths
  localparam int CoordW  = 14;
  localparam int SliceW  = 11;
  localparam int PitchW  = 14;
  localparam int AlignW  = 15;
  localparam int BppW    = 3;
  localparam int AddrW   = 32;
  localparam int RegIdxW = 2;
  localparam int CfgW    = 14;

  // Command codes
  localparam logic CMD_OFFSET = 1'b0;
  localparam logic CMD_BOUND  = 1'b1;

  // Register indexes
  localparam logic [RegIdxW-1:0] REG_VOLUME_MODE  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_ROW_PITCH    = 2'd1;
  localparam logic [RegIdxW-1:0] REG_SLICE_HEIGHT = 2'd2;
  localparam logic [RegIdxW-1:0] REG_BLOCK_BYTES  = 2'd3;

  // Reset values
  localparam logic [PitchW-1:0] PITCH_RESET  = 14'd32;
  localparam logic [PitchW-1:0] HEIGHT_RESET = 14'd32;
  localparam logic [BppW-1:0]   BPP_RESET    = 3'd2;

  // Layout constants
  localparam logic [AddrW-1:0] OFF_HI_MASK   = 32'h0000_01FF;
  localparam logic [AddrW-1:0] OFF_BANK_MASK = 32'h0000_01C0;
  localparam logic [AddrW-1:0] OFF_LO_MASK   = 32'h0000_003F;
  localparam logic [AddrW-1:0] MACRO_MASK    = 32'h0FFF_FFFF;
  localparam logic [AddrW-1:0] NIBBLE_MASK   = 32'h0000_000F;
  localparam logic [AddrW-1:0] BOUND_2D_B0   = 32'h0000_0A00;
  localparam logic [AddrW-1:0] BOUND_B1      = 32'h0000_0C00;
  localparam logic [AddrW-1:0] BOUND_BASE    = 32'h0000_0400;
  localparam logic [AddrW-1:0] BOUND_3D_BASE = 32'h0000_0800;

  // Configuration as seen by the datapath, pitch and height already aligned
  typedef struct packed {
    logic              volume_mode;
    logic [AlignW-1:0] pitch_al;
    logic [AlignW-1:0] height_al;
    logic [BppW-1:0]   bpp_log2;
  } cfg_t;

  // Effective coordinates of one item
  typedef struct packed {
    logic              cmd;
    logic              empty;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [SliceW-1:0] z;
  } coord_t;

  typedef struct packed {
    coord_t      c;
    logic [19:0] prod;
  } stage1_t;

  typedef struct packed {
    coord_t      c;
    logic [30:0] row;
  } stage2_t;

  typedef struct packed {
    coord_t           c;
    logic [AddrW-1:0] lin;
    logic [2:0]       pipe;
    logic [AddrW-1:0] bound_add;
  } stage3_t;

endpackage

// File: rtl/core/tiled_texture_address.sv
// Tiled texture block-address swizzler, five register stages.
// Each item is registered in s0, then moves through s1, s2 and s3 into byte_address.
// Throughput: one item per cycle; in_stall rises only while the output is
// stalled and every stage holds an item. Depth comes from two dependent
// multiplies (slice row, then pitch) followed by two stages of bit mixing.
// Reset clears all stage valid bits and loads the register reset values.
module tiled_texture_address
  import tta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [CoordW-1:0]  x_coord,
  input  logic [CoordW-1:0]  y_coord,
  input  logic [SliceW-1:0]  z_coord,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [AddrW-1:0]   byte_address
);

  logic              volume_mode;
  logic [PitchW-1:0] row_pitch;
  logic [PitchW-1:0] slice_height;
  logic [BppW-1:0]   bpp_log2;
  cfg_t              cfg;

  logic [3:0] vld;
  logic [4:0] rdy;

  coord_t  s0;
  coord_t  s0_next;
  stage1_t s1;
  stage1_t s1_next;
  stage2_t s2;
  stage2_t s2_next;
  stage3_t s3;
  stage3_t s3_next;
  logic [AddrW-1:0] addr_next;

  logic [CoordW-1:0] x_m1;
  logic [CoordW-1:0] y_m1;
  logic [SliceW-1:0] z_m1;
  logic [8:0]        mul_a;
  logic [10:0]       mul_b;
  logic [20:0]       row_sum;
  logic [AddrW-1:0]  swz_2d;
  logic [AddrW-1:0]  swz_3d;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_mode  <= 1'b0;
      row_pitch    <= PITCH_RESET;
      slice_height <= HEIGHT_RESET;
      bpp_log2     <= BPP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VOLUME_MODE:  volume_mode  <= cfg_data[0];
        REG_ROW_PITCH:    row_pitch    <= cfg_data[PitchW-1:0];
        REG_SLICE_HEIGHT: slice_height <= cfg_data[PitchW-1:0];
        REG_BLOCK_BYTES:  bpp_log2     <= cfg_data[BppW-1:0];
        default: ;
      endcase
    end
  end

  // Align pitch and height up to the tile size
  always_comb begin
    cfg.volume_mode = volume_mode;
    cfg.pitch_al    = ({1'b0, row_pitch} + 15'd31) & ~15'h1F;
    cfg.height_al   = ({1'b0, slice_height} + 15'd31) & ~15'h1F;
    cfg.bpp_log2    = bpp_log2;
  end

  // Per-stage ready: a stage takes new data when empty or when it moves on
  always_comb begin
    rdy[4] = !out_valid || !out_stall;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end
  assign in_stall = !rdy[0];

  // Stage 0: effective coordinates, tile origin of the last block for a bound
  always_comb begin
    x_m1          = x_coord - 14'd1;
    y_m1          = y_coord - 14'd1;
    z_m1          = z_coord - 11'd1;
    s0_next.cmd   = cmd;
    s0_next.empty = (cmd == CMD_BOUND) &&
                    (x_coord == '0 || y_coord == '0 || (volume_mode && z_coord == '0));
    if (cmd == CMD_BOUND) begin
      s0_next.x = x_m1 & ~14'h1F;
      s0_next.y = y_m1 & ~14'h1F;
      s0_next.z = z_m1 & ~11'h3;
    end else begin
      s0_next.x = x_coord;
      s0_next.y = y_coord;
      s0_next.z = z_coord;
    end
  end

  // Stage 1: slice row product (3D) or row-of-tiles product (2D)
  always_comb begin
    mul_a        = volume_mode ? s0.z[SliceW-1:2] : s0.y[CoordW-1:5];
    mul_b        = volume_mode ? cfg.height_al[AlignW-1:4] : {1'b0, cfg.pitch_al[AlignW-1:5]};
    s1_next.c    = s0;
    s1_next.prod = mul_a * mul_b;
  end

  // Stage 2: scale the outer row by the pitch in tiles (3D)
  always_comb begin
    row_sum   = {11'd0, s1.c.y[CoordW-1:4]} + {1'b0, s1.prod};
    s2_next.c = s1.c;
    if (volume_mode) begin
      s2_next.row = row_sum * cfg.pitch_al[AlignW-1:5];
    end else begin
      s2_next.row = {11'd0, s1.prod};
    end
  end

  // Stage 3: linear offset, pipe bits and bound constant
  tta_mix u_mix (
    .cfg     (cfg),
    .s2      (s2),
    .s3_next (s3_next)
  );

  // Stage 4: interleave bank and pipe bits into the final address
  always_comb begin
    swz_2d = ((s3.lin & ~OFF_HI_MASK) << 3) + {20'd0, s3.c.y[4], 11'd0}
           + ((s3.lin & OFF_BANK_MASK) << 2) + {24'd0, s3.pipe[1:0], 6'd0}
           + (s3.lin & OFF_LO_MASK);
    swz_3d = {s3.lin[28:9], s3.pipe[0], s3.lin[8:6], s3.pipe[2:1], s3.lin[5:0]};
    if (s3.c.empty) begin
      addr_next = '0;
    end else begin
      addr_next = (volume_mode ? swz_3d : swz_2d) + s3.bound_add;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
      if (rdy[4]) out_valid <= vld[3];
    end
  end

  // Advance payload on each transfer between stages
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) s0 <= s0_next;
    if (rdy[1] && vld[0])   s1 <= s1_next;
    if (rdy[2] && vld[1])   s2 <= s2_next;
    if (rdy[3] && vld[2])   s3 <= s3_next;
    if (rdy[4] && vld[3])   byte_address <= addr_next;
  end

endmodule

// File: rtl/core/tta_mix.sv
module tta_mix
  import tta_pkg::*;
(
  input  cfg_t    cfg,
  input  stage2_t s2,
  output stage3_t s3_next
);

  logic [AddrW-1:0] base;
  logic [3:0]       sh6;
  logic [3:0]       sh7;
  logic [AddrW-1:0] macro2;
  logic [AddrW-1:0] macro3;
  logic [5:0]       micro2_sum;
  logic [5:0]       micro3_sum;
  logic [AddrW-1:0] micro2;
  logic [AddrW-1:0] micro3;
  logic [AddrW-1:0] off;
  logic [AddrW-1:0] lin;
  logic             bank;
  logic [1:0]       pipe_hi;
  logic [1:0]       bank2;
  logic [AddrW-1:0] bound_3d;
  logic [AddrW-1:0] bound_2d;

  // Macro-tile base and micro-tile offsets
  always_comb begin
    base       = AddrW'(s2.c.x[CoordW-1:5]) + AddrW'(s2.row);
    sh6        = {1'b0, cfg.bpp_log2} + 4'd6;
    sh7        = {1'b0, cfg.bpp_log2} + 4'd7;
    macro2     = base << sh7;
    macro3     = ((base << sh6) & MACRO_MASK) << 1;
    micro2_sum = {3'b000, s2.c.x[2:0]} + {s2.c.y[3:1], 3'b000};
    micro3_sum = {3'b000, s2.c.x[2:0]} + {1'b0, s2.c.y[2:1], 3'b000};
    micro2     = AddrW'(micro2_sum) << cfg.bpp_log2;
    micro3     = AddrW'(micro3_sum) << cfg.bpp_log2;
  end

  // Linear offset inside the tile
  always_comb begin
    off = macro2 + ((micro2 & ~NIBBLE_MASK) << 1) + (micro2 & NIBBLE_MASK)
        + {27'd0, s2.c.y[0], 4'd0};
    lin = ((macro3 + (micro3 & ~NIBBLE_MASK)) << 1) + (micro3 & NIBBLE_MASK)
        + (AddrW'(s2.c.z[1:0]) << sh6) + {27'd0, s2.c.y[0], 4'd0};
  end

  // Bank and pipe bits
  always_comb begin
    bank    = s2.c.y[3] ^ s2.c.z[2];
    pipe_hi = s2.c.x[4:3] + {bank, 1'b0};
    bank2   = s2.c.x[4:3] + {s2.c.y[3], 1'b0};
  end

  // Per-size constant for the upper bound
  always_comb begin
    if (cfg.bpp_log2 == 3'd0) begin
      bound_3d = (AddrW'(cfg.pitch_al[AlignW-1:6]) << 12) + BOUND_B1
               + {21'd0, cfg.pitch_al[5], 10'd0};
    end else begin
      bound_3d = ((AddrW'(cfg.pitch_al) << 6) + BOUND_3D_BASE) << cfg.bpp_log2;
    end
    case (cfg.bpp_log2)
      3'd0:    bound_2d = BOUND_2D_B0;
      3'd1:    bound_2d = BOUND_B1;
      default: bound_2d = BOUND_BASE << cfg.bpp_log2;
    endcase
  end

  // Assemble the next stage
  always_comb begin
    s3_next.c    = s2.c;
    s3_next.lin  = cfg.volume_mode ? lin : off;
    s3_next.pipe = cfg.volume_mode ? {pipe_hi, bank} : {1'b0, bank2};
    if (s2.c.cmd == CMD_BOUND) begin
      s3_next.bound_add = cfg.volume_mode ? bound_3d : bound_2d;
    end else begin
      s3_next.bound_add = '0;
    end
  end

endmodule

// File: rtl/core/tta_checker.sv
module tta_checker
  import tta_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               cmd,
  input logic [CoordW-1:0]  x_coord,
  input logic               out_valid,
  input logic               out_stall,
  input logic [AddrW-1:0]   byte_address
);

  logic       in_xfer;
  logic       out_xfer;
  logic [2:0] inflight;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Track items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + {2'b00, in_xfer} - {2'b00, out_xfer};
    end
  end

  // A held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_address))
    else $error("result changed while stalled");

  // Input backpressure only comes from a stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_stall)
    else $error("input stalled with output free");

  // No more items in flight than stages, and no result from nothing
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd5 && (!out_valid || inflight != 3'd0))
    else $error("item count out of range");

  // An empty region bound gives zero once it has passed all stages with the output free
  a_empty_bound: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && cmd == CMD_BOUND && x_coord == '0) ##1 !out_stall ##1 !out_stall
      ##1 !out_stall ##1 !out_stall |=> out_valid && byte_address == '0)
    else $error("empty region bound not zero");

endmodule

bind tiled_texture_address tta_checker u_tta_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .cmd          (cmd),
  .x_coord      (x_coord),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .byte_address (byte_address)
);

// File: dv/testbench.sv
module testbench;
  import tta_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 2000;
  localparam int HoldCycles  = 80;
  localparam int PhaseCount  = 11;
  localparam int PhaseItems  = 57;
  localparam int DrainCycles = 10;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  typedef struct {
    logic              volume;
    logic              cmd;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [SliceW-1:0] z;
    bit                fixed;
    logic [AddrW-1:0]  addr;
  } stim_row_t;

  typedef struct {
    logic              volume;
    logic [PitchW-1:0] pitch;
    logic [PitchW-1:0] height;
    logic [BppW-1:0]   bpp;
  } layout_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [RegIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               cmd;
  logic [CoordW-1:0]  x_coord;
  logic [CoordW-1:0]  y_coord;
  logic [SliceW-1:0]  z_coord;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [AddrW-1:0]   byte_address;

  // Layout as programmed into the block
  logic              layout_volume;
  logic [PitchW-1:0] layout_pitch;
  logic [PitchW-1:0] layout_height;
  logic [BppW-1:0]   layout_bpp;

  logic [AddrW-1:0] offered_address;
  logic [AddrW-1:0] pending_addresses[$];
  int               mismatch_count = 0;
  int               idle_cycles = 0;
  int               burst_left = 0;
  int               hold_requests = 0;
  int               hold_served = 0;
  int               hold_left = 0;
  int               mode_left = 0;
  stall_mode_t      stall_mode = STALL_NONE;

  // Directed rows: reset layout (2D, pitch 32, height 32, 4-byte blocks), then 3D
  stim_row_t directed_rows[24] = '{
    '{1'b0, CMD_OFFSET, 14'd0,     14'd0,     11'd0,    1'b1, 32'h0},
    '{1'b0, CMD_BOUND,  14'd0,     14'd5,     11'd0,    1'b1, 32'h0},
    '{1'b0, CMD_BOUND,  14'd5,     14'd0,     11'd0,    1'b1, 32'h0},
    '{1'b0, CMD_BOUND,  14'd1,     14'd1,     11'd0,    1'b1, 32'h1000},
    '{1'b0, CMD_OFFSET, 14'd16383, 14'd16383, 11'd2047, 1'b0, 32'h0},
    '{1'b0, CMD_BOUND,  14'd16383, 14'd16383, 11'd2047, 1'b0, 32'h0},
    '{1'b0, CMD_OFFSET, 14'd8192,  14'd8192,  11'd1024, 1'b0, 32'h0},
    '{1'b0, CMD_BOUND,  14'd8192,  14'd8192,  11'd1024, 1'b0, 32'h0},
    '{1'b0, CMD_OFFSET, 14'd31,    14'd31,    11'd0,    1'b0, 32'h0},
    '{1'b0, CMD_OFFSET, 14'd32,    14'd1,     11'd0,    1'b0, 32'h0},
    '{1'b0, CMD_BOUND,  14'd33,    14'd33,    11'd0,    1'b0, 32'h0},
    '{1'b0, CMD_OFFSET, 14'd5,     14'd9,     11'd3,    1'b0, 32'h0},
    '{1'b1, CMD_OFFSET, 14'd0,     14'd0,     11'd0,    1'b1, 32'h0},
    '{1'b1, CMD_BOUND,  14'd1,     14'd1,     11'd0,    1'b1, 32'h0},
    '{1'b1, CMD_BOUND,  14'd0,     14'd1,     11'd1,    1'b1, 32'h0},
    '{1'b1, CMD_BOUND,  14'd1,     14'd0,     11'd1,    1'b1, 32'h0},
    '{1'b1, CMD_BOUND,  14'd1,     14'd1,     11'd1,    1'b1, 32'h4000},
    '{1'b1, CMD_OFFSET, 14'd16383, 14'd16383, 11'd2047, 1'b0, 32'h0},
    '{1'b1, CMD_BOUND,  14'd16383, 14'd16383, 11'd2047, 1'b0, 32'h0},
    '{1'b1, CMD_OFFSET, 14'd8192,  14'd8192,  11'd1024, 1'b0, 32'h0},
    '{1'b1, CMD_BOUND,  14'd8192,  14'd8192,  11'd1024, 1'b0, 32'h0},
    '{1'b1, CMD_OFFSET, 14'd7,     14'd15,    11'd3,    1'b0, 32'h0},
    '{1'b1, CMD_OFFSET, 14'd9,     14'd24,    11'd6,    1'b0, 32'h0},
    '{1'b1, CMD_BOUND,  14'd40,    14'd40,    11'd5,    1'b0, 32'h0}
  };

  // Fixed layouts first (extremes among them), the rest drawn at random
  layout_t fixed_layouts[8] = '{
    '{1'b0, 14'd32,    14'd32,    3'd2},
    '{1'b0, 14'd1,     14'd1,     3'd0},
    '{1'b0, 14'd8192,  14'd8192,  3'd4},
    '{1'b1, 14'd16383, 14'd16383, 3'd7},
    '{1'b1, 14'd0,     14'd0,     3'd5},
    '{1'b1, 14'd100,   14'd50,    3'd1},
    '{1'b1, 14'd8192,  14'd1,     3'd3},
    '{1'b0, 14'd0,     14'd16383, 3'd6}
  };

  tiled_texture_address i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .z_coord     (z_coord),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_address(byte_address)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] align_tile(logic [31:0] v);
    return (v + 32'd31) & ~32'd31;
  endfunction

  function automatic logic [31:0] tiled_offset_2d(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] pitch, logic [31:0] b);
    logic [31:0] p, macro, micro, off;
    p     = align_tile(pitch);
    macro = ((x >> 5) + (y >> 5) * (p >> 5)) << (b + 32'd7);
    micro = ((x & 32'd7) + ((y & 32'hE) << 2)) << b;
    off   = macro + ((micro & ~32'hF) << 1) + (micro & 32'hF) + ((y & 32'd1) << 4);
    return ((off & ~32'h1FF) << 3) + ((y & 32'd16) << 7) + ((off & 32'h1C0) << 2) +
           (((((y & 32'd8) >> 2) + (x >> 3)) & 32'd3) << 6) + (off & 32'h3F);
  endfunction

  function automatic logic [31:0] tiled_offset_3d(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic [31:0] pitch,
                                                  logic [31:0] height, logic [31:0] b);
    logic [31:0] p, h, outer_row, macro, micro, bank, pipe, lin, a;
    p         = align_tile(pitch);
    h         = align_tile(height);
    outer_row = ((y >> 4) + (z >> 2) * (h >> 4)) * (p >> 5);
    macro     = ((((x >> 5) + outer_row) << (b + 32'd6)) & 32'h0FFF_FFFF) << 1;
    micro     = ((x & 32'd7) + ((y & 32'd6) << 2)) << b;
    bank      = ((y >> 3) + (z >> 2)) & 32'd1;
    pipe      = bank + ((((x >> 3) + (bank << 1)) & 32'd3) << 1);
    lin       = ((macro + (micro & ~32'd15)) << 1) + (micro & 32'd15) +
                ((z & 32'd3) << (b + 32'd6)) + ((y & 32'd1) << 4);
    // Interleave pipe and bank bits between the low and high linear offset
    a = (pipe & 32'd1) << 3;
    a = a + ((lin >> 6) & 32'd7);
    a = a << 3;
    a = a + (pipe & ~32'd1);
    a = a << 2;
    a = a + (lin & ~32'd511);
    a = a << 3;
    a = a + (lin & 32'd63);
    return a;
  endfunction

  // Expected byte_address for one item under the programmed layout
  function automatic logic [31:0] swizzle_address(logic c, logic [CoordW-1:0] xc,
                                                  logic [CoordW-1:0] yc,
                                                  logic [SliceW-1:0] zc);
    logic [31:0] x, y, z, pitch, height, b, p, ub;
    x      = 32'(xc);
    y      = 32'(yc);
    z      = 32'(zc);
    pitch  = 32'(layout_pitch);
    height = 32'(layout_height);
    b      = 32'(layout_bpp);
    if (c == CMD_OFFSET) begin
      if (layout_volume) return tiled_offset_3d(x, y, z, pitch, height, b);
      return tiled_offset_2d(x, y, pitch, b);
    end
    // Upper bound: empty regions give zero
    if (x == 0 || y == 0 || (layout_volume && z == 0)) return 32'd0;
    if (layout_volume) begin
      ub = tiled_offset_3d((x - 1) & ~32'd31, (y - 1) & ~32'd31, (z - 1) & ~32'd3,
                           pitch, height, b);
      p  = align_tile(pitch);
      if (b == 0) ub = ub + ((p >> 6) << 12) + 32'hC00 + ((p & 32'd32) << 5);
      else        ub = ub + (((p << 6) + 32'h800) << b);
    end else begin
      ub = tiled_offset_2d((x - 1) & ~32'd31, (y - 1) & ~32'd31, pitch, b);
      if (b == 0)      ub = ub + 32'hA00;
      else if (b == 1) ub = ub + 32'hC00;
      else             ub = ub + (32'h400 << b);
    end
    return ub;
  endfunction

  function automatic logic [CoordW-1:0] rand_extent();
    case ($urandom_range(0, 3))
      0: return CoordW'($urandom_range(0, 16383));
      1: return CoordW'($urandom_range(0, 70));
      2: return CoordW'($urandom_range(0, 511) * 32 + $urandom_range(0, 2) - 1);
      default: return CoordW'($urandom_range(8180, 8200));
    endcase
  endfunction

  function automatic logic [SliceW-1:0] rand_slice();
    case ($urandom_range(0, 3))
      0: return SliceW'($urandom_range(0, 2047));
      1: return SliceW'($urandom_range(0, 9));
      2: return SliceW'($urandom_range(0, 511) * 4 + $urandom_range(0, 2) - 1);
      default: return SliceW'($urandom_range(1020, 1030));
    endcase
  endfunction

  // Count transfers on both channels, check results in order, watch for a hang
  always @(posedge clk) begin
    logic [AddrW-1:0] expected;
    logic             moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_addresses.push_back(offered_address);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_addresses.size() == 0) begin
          $display("%0t: byte_address mismatch: expected no transfer, got %h",
                   $time, byte_address);
          mismatch_count++;
        end else begin
          expected = pending_addresses.pop_front();
          if (byte_address !== expected) begin
            $display("%0t: byte_address mismatch: expected %h, got %h",
                     $time, expected, byte_address);
            mismatch_count++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HoldCycles - 1;
      out_stall = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall = 1'b0;
        STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
        default:     out_stall = ~out_stall;
      endcase
    end
  end

  // Offer one item and hold it until the transfer; call and return at a falling edge
  task automatic send_item(logic c, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                           logic [SliceW-1:0] z, logic [AddrW-1:0] addr);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    cmd             = c;
    x_coord         = x;
    y_coord         = y;
    z_coord         = z;
    offered_address = addr;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_addresses.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    case (idx)
      REG_VOLUME_MODE:  layout_volume = data[0];
      REG_ROW_PITCH:    layout_pitch  = data;
      REG_SLICE_HEIGHT: layout_height = data;
      REG_BLOCK_BYTES:  layout_bpp    = data[BppW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    layout_t           lay;
    logic              c;
    logic [CoordW-1:0] x, y;
    logic [SliceW-1:0] z;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    cmd             = CMD_OFFSET;
    x_coord         = '0;
    y_coord         = '0;
    z_coord         = '0;
    offered_address = '0;
    layout_volume   = 1'b0;
    layout_pitch    = PITCH_RESET;
    layout_height   = HEIGHT_RESET;
    layout_bpp      = BPP_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed items, switching to 3D once the queue is empty
    foreach (directed_rows[i]) begin
      if (directed_rows[i].volume != layout_volume) begin
        wait_drained();
        write_reg(REG_VOLUME_MODE, CfgW'(directed_rows[i].volume));
      end
      send_item(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].z,
                directed_rows[i].fixed ? directed_rows[i].addr :
                swizzle_address(directed_rows[i].cmd, directed_rows[i].x,
                                directed_rows[i].y, directed_rows[i].z));
    end

    // Random items under a sequence of layouts
    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph < 8) begin
        lay = fixed_layouts[ph];
      end else begin
        lay.volume = 1'($urandom_range(0, 1));
        lay.pitch  = PitchW'($urandom_range(1, 8192));
        lay.height = PitchW'($urandom_range(1, 8192));
        lay.bpp    = BppW'($urandom_range(0, 4));
      end
      wait_drained();
      write_reg(REG_VOLUME_MODE, CfgW'(lay.volume));
      write_reg(REG_ROW_PITCH, lay.pitch);
      write_reg(REG_SLICE_HEIGHT, lay.height);
      write_reg(REG_BLOCK_BYTES, CfgW'(lay.bpp));
      // Hold off the receiver so the pipeline fills and stalls its input
      if (ph == 3 || ph == 9) hold_requests++;
      for (int n = 0; n < PhaseItems; n++) begin
        c = ($urandom_range(0, 1) == 0) ? CMD_OFFSET : CMD_BOUND;
        x = rand_extent();
        y = rand_extent();
        z = rand_slice();
        if (c == CMD_BOUND && $urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0: x = '0;
            1: y = '0;
            default: z = '0;
          endcase
        end
        send_item(c, x, y, z, swizzle_address(c, x, y, z));
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_addresses.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
